// File: src/oicuf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oicuf_pkg
// shared constants of the online island counter: command codes, neighbour
// order, configuration register indexes and saturation limits
// ----------------------------------------------------------------------------
package oicuf_pkg;

    // command codes of the func field
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // neighbour visiting order
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // configuration register indexes
    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    localparam int unsigned COUNT_MAX = 8191;
    localparam logic [3:0]  RANK_MAX  = 4'd15;

endpackage : oicuf_pkg
`default_nettype wire

// File: src/oicuf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oicuf_ram
// generic simple dual-port ram: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module oicuf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : oicuf_ram
`default_nettype wire

// File: src/online_island_count_union_find_unit.sv
`default_nettype none
// an add checks the cell, then per land neighbour walks to the root of the cell and of
//   the neighbour, compressing each path on the way, and links the two roots if they
//   differ, all on one ram port
// an out-of-range or repeat cell skips the neighbour walks; one transfer in flight at a time
// a clear writes every one of the MAX_ROWS*MAX_COLS cells (one cell written per cycle)
// reset: a clearing pass over all MAX_ROWS*MAX_COLS cells runs with in_stall high
// ----------------------------------------------------------------------------
// online_island_count_union_find_unit
// counts 4-connected land regions on a grid as cells turn to land, using
// union-find with path compression and union by rank in one cell memory
// ----------------------------------------------------------------------------
module online_island_count_union_find_unit
    import oicuf_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [5:0]  row,
    input  wire logic [5:0]  col,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [12:0]      island_count,
    output logic             coord_error,
    output logic             already_land
);

    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW       = $clog2(CELLS + 1);
    localparam int WW       = AW + 5;
    localparam int ROWS_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COLS_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam logic [AW-1:0] COLS_W = AW'(MAX_COLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_NB, S_NBD, S_FSTART, S_FIND, S_CSTART,
        S_COMP, S_FDONE, S_UNION, S_RANK, S_NEXT, S_OUT
    } state_t;

    state_t          state_reg;
    logic [6:0]      num_rows_reg;
    logic [6:0]      num_cols_reg;
    logic            func_reg;
    logic [5:0]      row_reg;
    logic [5:0]      col_reg;
    logic [AW-1:0]   cell_reg;
    logic [AW-1:0]   nb_reg;
    logic [AW-1:0]   cur_reg;
    logic [AW-1:0]   start_reg;
    logic [AW-1:0]   root_reg;
    logic [3:0]      root_rank_reg;
    logic [AW-1:0]   ra_reg;
    logic [3:0]      rank_a_reg;
    logic            phase_reg;
    logic [1:0]      k_reg;
    logic [AW-1:0]   idx_reg;
    logic            clr_pend_reg;
    logic [CW-1:0]   count_reg;
    logic            cerr_reg;
    logic            dup_reg;
    logic            out_valid_reg;
    logic [12:0]     island_count_reg;
    logic            coord_error_reg;
    logic            already_land_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [WW-1:0]   ram_rdata;

    logic [AW-1:0]   rd_link;
    logic [3:0]      rd_rank;
    logic            rd_land;
    logic [6:0]      rows_eff;
    logic [6:0]      cols_eff;
    logic            coord_bad;
    logic [6:0]      nr;
    logic [6:0]      nc;
    logic            nb_under;
    logic            nb_ok;
    logic [AW-1:0]   nb_addr;
    logic [AW-1:0]   in_addr;
    logic            out_free;
    logic [12:0]     count_sat;

    assign rd_link = ram_rdata[AW-1:0];
    assign rd_rank = ram_rdata[AW+3:AW];
    assign rd_land = ram_rdata[AW+4];

    assign rows_eff = (num_rows_reg > 7'(ROWS_CAP)) ? 7'(ROWS_CAP) : num_rows_reg;
    assign cols_eff = (num_cols_reg > 7'(COLS_CAP)) ? 7'(COLS_CAP) : num_cols_reg;

    // out-of-range test of the latched coordinate
    assign coord_bad = ({1'b0, row_reg} >= rows_eff) || ({1'b0, col_reg} >= cols_eff);

    // neighbour of the current cell in visiting order
    always_comb
    begin
        nr       = {1'b0, row_reg};
        nc       = {1'b0, col_reg};
        nb_under = 1'b0;
        case (k_reg)
            DIR_DOWN:  nr = {1'b0, row_reg} + 7'd1;
            DIR_RIGHT: nc = {1'b0, col_reg} + 7'd1;
            DIR_UP:
            begin
                nr       = {1'b0, row_reg} - 7'd1;
                nb_under = (row_reg == 6'd0);
            end
            DIR_LEFT:
            begin
                nc       = {1'b0, col_reg} - 7'd1;
                nb_under = (col_reg == 6'd0);
            end
            default: nb_under = 1'b1;
        endcase
    end

    assign nb_ok   = !nb_under && (nr < rows_eff) && (nc < cols_eff);
    assign nb_addr = AW'(nr) * COLS_W + AW'(nc);
    assign in_addr = AW'(row) * COLS_W + AW'(col);

    assign out_free  = !out_valid_reg || !out_stall;
    assign count_sat = (32'(count_reg) > 32'(COUNT_MAX)) ? 13'(COUNT_MAX) : 13'(count_reg);

    // ram read address and write port
    always_comb
    begin
        ram_raddr = cur_reg;
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = {1'b0, 4'd0, cur_reg};
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {1'b0, 4'd0, idx_reg};
            end
            S_IDLE:  ram_raddr = in_addr;
            S_CHECK:
            begin
                ram_we    = (func_reg == FUNC_ADD) && !coord_bad && !rd_land;
                ram_waddr = cell_reg;
                ram_wdata = {1'b1, 4'd0, cell_reg};
            end
            S_NB:    ram_raddr = nb_addr;
            S_FSTART: ram_raddr = cur_reg;
            S_FIND:  ram_raddr = rd_link;
            S_CSTART: ram_raddr = cur_reg;
            S_COMP:
            begin
                ram_raddr = rd_link;
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = {rd_land, rd_rank, root_reg};
            end
            S_UNION:
            begin
                ram_we = 1'b1;
                if (rank_a_reg < root_rank_reg)
                begin
                    ram_waddr = ra_reg;
                    ram_wdata = {1'b1, rank_a_reg, root_reg};
                end
                else
                begin
                    ram_waddr = root_reg;
                    ram_wdata = {1'b1, root_rank_reg, ra_reg};
                end
            end
            S_RANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ra_reg;
                ram_wdata = {1'b1, rank_a_reg + 4'd1, ra_reg};
            end
            default: ram_raddr = cur_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            num_rows_reg     <= 7'd64;
            num_cols_reg     <= 7'd64;
            idx_reg          <= '0;
            clr_pend_reg     <= 1'b0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= 1'b0;
            k_reg            <= DIR_DOWN;
            cerr_reg         <= 1'b0;
            dup_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                    CFG_NUM_COLS: num_cols_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_reg == LAST_CELL)
                    begin
                        idx_reg   <= '0;
                        state_reg <= clr_pend_reg ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func;
                        row_reg   <= row;
                        col_reg   <= col;
                        cell_reg  <= in_addr;
                        cerr_reg  <= 1'b0;
                        dup_reg   <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    k_reg <= DIR_DOWN;
                    if (func_reg == FUNC_CLEAR)
                    begin
                        count_reg    <= '0;
                        clr_pend_reg <= 1'b1;
                        idx_reg      <= '0;
                        state_reg    <= S_CLEAR;
                    end
                    else if (coord_bad)
                    begin
                        cerr_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (rd_land)
                    begin
                        dup_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_NB;
                    end
                end
                S_NB:
                begin
                    nb_reg    <= nb_addr;
                    state_reg <= nb_ok ? S_NBD : S_NEXT;
                end
                S_NBD:
                begin
                    if (rd_land)
                    begin
                        phase_reg <= 1'b0;
                        cur_reg   <= cell_reg;
                        start_reg <= cell_reg;
                        state_reg <= S_FSTART;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_FSTART: state_reg <= S_FIND;
                S_FIND:
                begin
                    if (rd_link == cur_reg)
                    begin
                        root_reg      <= cur_reg;
                        root_rank_reg <= rd_rank;
                        cur_reg       <= start_reg;
                        state_reg     <= (start_reg == cur_reg) ? S_FDONE : S_CSTART;
                    end
                    else
                    begin
                        cur_reg <= rd_link;
                    end
                end
                S_CSTART: state_reg <= S_COMP;
                S_COMP:
                begin
                    // point each node on the path straight at the root
                    if (rd_link == root_reg)
                    begin
                        state_reg <= S_FDONE;
                    end
                    else
                    begin
                        cur_reg <= rd_link;
                    end
                end
                S_FDONE:
                begin
                    if (!phase_reg)
                    begin
                        ra_reg     <= root_reg;
                        rank_a_reg <= root_rank_reg;
                        phase_reg  <= 1'b1;
                        cur_reg    <= nb_reg;
                        start_reg  <= nb_reg;
                        state_reg  <= S_FSTART;
                    end
                    else
                    begin
                        state_reg <= (root_reg == ra_reg) ? S_NEXT : S_UNION;
                    end
                end
                S_UNION:
                begin
                    count_reg <= count_reg - CW'(1);
                    if (rank_a_reg == root_rank_reg && rank_a_reg != RANK_MAX)
                    begin
                        state_reg <= S_RANK;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_RANK: state_reg <= S_NEXT;
                S_NEXT:
                begin
                    k_reg     <= k_reg + 2'd1;
                    state_reg <= (k_reg == DIR_LEFT) ? S_OUT : S_NB;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        island_count_reg <= count_sat;
                        coord_error_reg  <= cerr_reg;
                        already_land_reg <= dup_reg;
                        clr_pend_reg     <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    oicuf_ram #(
        .WIDTH (WW),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign island_count = island_count_reg;
    assign coord_error  = coord_error_reg;
    assign already_land = already_land_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CELLS))
        else $error("region count above cell count");

    a_union_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNION) |-> (ra_reg != root_reg))
        else $error("union of a set with itself");

    a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |-> (cur_reg != root_reg))
        else $error("path compression rewrote the root");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("accepted transfer did not start work");
`endif

endmodule : online_island_count_union_find_unit
`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for online_island_count_union_find_unit
// drives add and clear commands under several idle and stall mixes, keeps a
// union-find model of the grid and checks every result against it in order
// ----------------------------------------------------------------------------
module testbench
    import oicuf_pkg::*;
;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic [12:0] count;
        logic        cerr;
        logic        dup;
    } island_result_t;

    class island_scoreboard;
        int unsigned rows_in_use;
        int unsigned cols_in_use;
        int unsigned parent [GRID_CELLS];
        int unsigned rank [GRID_CELLS];
        bit          land [GRID_CELLS];
        int unsigned regions;
        island_result_t pending [$];
        int          mismatches;

        function void clear_grid();
            for (int i = 0; i < GRID_CELLS; i++)
            begin
                parent[i] = i;
                rank[i] = 0;
                land[i] = 0;
            end
            regions = 0;
        endfunction

        function void set_register(logic index, logic [6:0] value);
            if (index == CFG_NUM_ROWS)
                rows_in_use = value;
            else
                cols_in_use = value;
        endfunction

        function int unsigned root_of(int unsigned x);
            int unsigned r;
            int unsigned nxt;
            r = x;
            while (parent[r] != r)
                r = parent[r];
            while (x != r)
            begin
                nxt = parent[x];
                parent[x] = r;
                x = nxt;
            end
            return r;
        endfunction

        function bit merge(int unsigned a, int unsigned b);
            int unsigned ra;
            int unsigned rb;
            ra = root_of(a);
            rb = root_of(b);
            if (ra == rb)
                return 0;
            if (rank[ra] < rank[rb])
                parent[ra] = rb;
            else
            begin
                parent[rb] = ra;
                if (rank[ra] == rank[rb] && rank[ra] < RANK_MAX)
                    rank[ra]++;
            end
            return 1;
        endfunction

        function void note_input(logic f, logic [5:0] r, logic [5:0] c);
            int rows;
            int cols;
            int nr;
            int nc;
            int unsigned cell_idx;
            island_result_t res;
            int dr [4] = '{1, 0, -1, 0};
            int dc [4] = '{0, 1, 0, -1};
            rows = rows_in_use > GRID_ROWS ? GRID_ROWS : rows_in_use;
            cols = cols_in_use > GRID_COLS ? GRID_COLS : cols_in_use;
            res = '0;
            if (f == FUNC_CLEAR)
                clear_grid();
            else if (int'(r) >= rows || int'(c) >= cols)
                res.cerr = 1;
            else
            begin
                cell_idx = r * GRID_COLS + c;
                if (land[cell_idx])
                    res.dup = 1;
                else
                begin
                    land[cell_idx] = 1;
                    regions++;
                    for (int k = 0; k < 4; k++)
                    begin
                        nr = int'(r) + dr[k];
                        nc = int'(c) + dc[k];
                        if (nr >= 0 && nc >= 0 && nr < rows && nc < cols)
                            if (land[nr * GRID_COLS + nc] && merge(cell_idx, nr * GRID_COLS + nc))
                                regions--;
                    end
                end
            end
            res.count = 13'(regions > COUNT_MAX ? COUNT_MAX : regions);
            pending = {pending, res};
        endfunction

        function void check_result(island_result_t got);
            island_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result count=%0d cerr=%0d dup=%0d",
                             got.count, got.cerr, got.dup);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected count=%0d cerr=%0d dup=%0d, got %0d %0d %0d",
                             want.count, want.cerr, want.dup, got.count, got.cerr, got.dup);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_index = CFG_NUM_ROWS;
    logic [6:0]  cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        func = FUNC_ADD;
    logic [5:0]  row = '0;
    logic [5:0]  col = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [12:0] island_count;
    logic        coord_error;
    logic        already_land;

    island_scoreboard board;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    always #1 clk = ~clk;

    online_island_count_union_find_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .row(row), .col(col), .out_valid(out_valid),
        .out_stall(out_stall), .island_count(island_count),
        .coord_error(coord_error), .already_land(already_land)
    );

    // result sampling and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result('{island_count, coord_error, already_land});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // valid stays high after the transfer until drain or an idle gap in the next call lowers it
    task automatic send(logic f, logic [5:0] r, logic [5:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        func <= f;
        row <= r;
        col <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(f, r, c);
        @(negedge clk);
    endtask

    task automatic drain(int tail);
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (tail)
            @(negedge clk);
    endtask

    // only while idle
    task automatic write_reg(logic index, logic [6:0] value);
        cfg_we <= 1;
        cfg_index <= index;
        cfg_data <= value;
        board.set_register(index, value);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    task automatic random_phase(int n, int rmax, int cmax);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                send(FUNC_CLEAR, 6'($urandom), 6'($urandom));
            else if (pick < 8)
                send(FUNC_ADD, 6'($urandom), 6'($urandom));
            else
                send(FUNC_ADD, 6'($urandom_range(rmax)), 6'($urandom_range(cmax)));
        end
    endtask

    initial
    begin
        board = new();
        board.rows_in_use = 64;
        board.cols_in_use = 64;
        board.clear_grid();
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        repeat (7)
            @(negedge clk);
        rst_n = 1;

        // directed: corners, repeats, joins, out of range, clear
        send(FUNC_ADD, 0, 0);
        send(FUNC_ADD, 0, 0);
        send(FUNC_ADD, 63, 63);
        send(FUNC_ADD, 0, 2);
        send(FUNC_ADD, 0, 1);
        send(FUNC_ADD, 1, 1);
        send(FUNC_ADD, 62, 63);
        send(FUNC_ADD, 63, 62);
        send(FUNC_ADD, 1, 0);
        send(FUNC_CLEAR, 6'h3f, 6'h3f);
        send(FUNC_ADD, 5, 5);
        drain(8);
        write_reg(CFG_NUM_ROWS, 7'd1);
        write_reg(CFG_NUM_COLS, 7'd127);
        send(FUNC_ADD, 1, 0);
        send(FUNC_ADD, 0, 4);
        send(FUNC_ADD, 0, 5);
        send(FUNC_ADD, 0, 63);
        drain(8);
        write_reg(CFG_NUM_ROWS, 7'd0);
        send(FUNC_ADD, 0, 0);
        drain(8);
        write_reg(CFG_NUM_ROWS, 7'd127);
        write_reg(CFG_NUM_COLS, 7'd1);
        send(FUNC_ADD, 6, 5);
        send(FUNC_ADD, 63, 0);
        send(FUNC_ADD, 62, 0);
        drain(8);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            case (ph)
                0: begin write_reg(CFG_NUM_ROWS, 7'd64); write_reg(CFG_NUM_COLS, 7'd64); end
                1: begin write_reg(CFG_NUM_ROWS, 7'd6);  write_reg(CFG_NUM_COLS, 7'd7);  end
                2: begin write_reg(CFG_NUM_ROWS, 7'd1);  write_reg(CFG_NUM_COLS, 7'd9);  end
                3: begin write_reg(CFG_NUM_ROWS, 7'd8);  write_reg(CFG_NUM_COLS, 7'd64); end
                default: begin
                    write_reg(CFG_NUM_ROWS, 7'($urandom_range(1, 12)));
                    write_reg(CFG_NUM_COLS, 7'($urandom_range(1, 12)));
                end
            endcase
            // dense small grids make long chains; larger grids are limited to their first 12 rows and columns
            random_phase(90, board.rows_in_use > 12 ? 11 : board.rows_in_use,
                         board.cols_in_use > 12 ? 11 : board.cols_in_use);
            drain(8);
        end
        drain(GRID_CELLS + 40);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("** online_island_count_union_find_unit: PASSED **");
        else
            $display("** online_island_count_union_find_unit: FAILED **");
        $finish;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("** online_island_count_union_find_unit: FAILED **");
        $finish;
    end
endmodule
